// ===== rtl/vlat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vlat_pkg: shared types and codes of the virtual loss table
// Request codes, internal operation codes, the command word that runs
// from the front part to the back part, and the result record.
// ----------------------------------------------------------------------------
package vlat_pkg;

	// request codes on req_type
	localparam logic [2:0] REQ_APPLY  = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_READ   = 3'd2;
	localparam logic [2:0] REQ_CLEAR  = 3'd3;
	localparam logic [2:0] REQ_STATS  = 3'd4;

	// operations after classification
	typedef logic [2:0] op_t;
	localparam op_t OP_APPLY  = 3'd0;
	localparam op_t OP_REMOVE = 3'd1;
	localparam op_t OP_READ   = 3'd2;
	localparam op_t OP_CLEAR  = 3'd3;
	localparam op_t OP_STATS  = 3'd4;
	localparam op_t OP_PEEK   = 3'd5;  // apply/remove while disabled
	localparam op_t OP_BAD    = 3'd6;  // unknown request

	// configuration register indexes
	localparam logic [1:0] CFG_ENABLE      = 2'd0;
	localparam logic [1:0] CFG_DEFAULT_MAG = 2'd1;
	localparam logic [1:0] CFG_NODE_COUNT  = 2'd2;

	// saturation limits of the statistics fields
	localparam logic [27:0] SUM_MAX    = 28'hFFF_FFFF;
	localparam logic [12:0] LOADED_MAX = 13'h1FFF;

	typedef struct packed {
		op_t         op;
		logic        idx_ok;
		logic [11:0] idx;
		logic [15:0] mag;
	} cmd_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] loss_value;
		logic [31:0] applies_done;
		logic [31:0] removes_done;
		logic [31:0] active_paths;
		logic [27:0] loss_sum;
		logic [12:0] loaded_nodes;
		logic [15:0] loss_max;
		logic [15:0] loss_avg;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/vlat_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vlat_front: request classifier
// Checks the index against the node count and table size, selects the
// magnitude and maps each request to an operation for the back part.
// ----------------------------------------------------------------------------
module vlat_front #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  wire  logic [2:0]     req_type,
	input  wire  logic [11:0]    entry_index,
	input  wire  logic [15:0]    magnitude,
	input  wire  logic           use_default,
	input  wire  logic           enable,
	input  wire  logic [15:0]    default_magnitude,
	input  wire  logic [12:0]    node_limit,
	output vlat_pkg::cmd_t       cmd
);
	import vlat_pkg::*;

	logic idx_ok;

	// index is valid below both the node count and the table depth
	assign idx_ok = (17'(entry_index) < 17'(node_limit)) &&
	                (17'(entry_index) < 17'(TABLE_ENTRIES));

	always_comb begin
		cmd.idx_ok = idx_ok;
		cmd.idx    = entry_index;
		cmd.mag    = use_default ? default_magnitude : magnitude;
		case (req_type)
			REQ_APPLY:  cmd.op = enable ? OP_APPLY : OP_PEEK;
			REQ_REMOVE: cmd.op = enable ? OP_REMOVE : OP_PEEK;
			REQ_READ:   cmd.op = OP_READ;
			REQ_CLEAR:  cmd.op = OP_CLEAR;
			REQ_STATS:  cmd.op = OP_STATS;
			default:    cmd.op = OP_BAD;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/vlat_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vlat_queue: two-entry command queue
// Parts the front from the back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module vlat_queue (
	input  wire  logic           clk,
	input  wire  logic           arst_n,
	input  wire  logic           push,
	input  wire  vlat_pkg::cmd_t push_cmd,
	input  wire  logic           pop,
	output vlat_pkg::cmd_t       head,
	output logic                 empty,
	output logic                 full
);
	import vlat_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

// ===== rtl/vlat_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vlat_divider: restoring divider for the statistics average
// One quotient bit per cycle; done rises once the last quotient bit is in.
// ----------------------------------------------------------------------------
module vlat_divider #(
	parameter int NW = 29,
	parameter int DW = 13
) (
	input  wire  logic          clk,
	input  wire  logic          arst_n,
	input  wire  logic          start,
	input  wire  logic [NW-1:0] num,
	input  wire  logic [DW-1:0] den,
	output logic                done,
	output logic [15:0]         quotient
);
	localparam int IW = $clog2(NW + 1);

	logic [NW-1:0] nq_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [IW-1:0] iter_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          take;

	// shift in the next numerator bit and try the subtract
	assign trial = {rem_q, nq_q[NW-1]};
	assign take  = (trial >= {1'b0, den_q});

	assign done     = done_q;
	assign quotient = nq_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				iter_q <= '0;
			end else if (run_q) begin
				iter_q <= iter_q + IW'(1);
				if (iter_q == IW'(NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			nq_q  <= {nq_q[NW-2:0], take};
			rem_q <= take ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vlat_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vlat_back: execution part of the virtual loss table
// Holds the table memory and the operation counters, runs the
// read-modify-write of apply/remove/read, the clear and statistics sweeps,
// and the clearing pass after reset.
// ----------------------------------------------------------------------------
module vlat_back #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int LOSS_LIMIT    = 64000
) (
	input  wire  logic           clk,
	input  wire  logic           arst_n,
	input  wire  logic [12:0]    node_limit,
	input  wire  logic           q_empty,
	input  wire  vlat_pkg::cmd_t q_head,
	output logic                 q_pop,
	output logic                 init_busy,
	output logic                 res_valid,
	output vlat_pkg::res_t       res
);
	import vlat_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int SW = 16 + CW;

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_CLR  = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;

	logic [15:0]   mem [TABLE_ENTRIES];
	logic [15:0]   rd_data_q;

	logic [2:0]    state_q;
	cmd_t          cmd_q;
	logic [CW-1:0] ptr_q;
	logic          rv_q;
	logic [SW-1:0] sum_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   max_q;
	logic [31:0]   apply_cnt_q;
	logic [31:0]   remove_cnt_q;

	logic          done_q;
	logic          ok_q;
	logic [15:0]   value_q;
	logic [27:0]   sum_out_q;
	logic [12:0]   loaded_q;
	logic [15:0]   max_out_q;
	logic [15:0]   avg_q;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [15:0]   mem_wd;
	logic [AW-1:0] mem_ra;
	logic [CW-1:0] lim;
	logic          sweep_go;
	logic [16:0]   add_sum;
	logic          over;
	logic [15:0]   sub_val;
	logic [15:0]   new_val;
	logic          div_start;
	logic          div_done;
	logic [15:0]   div_quo;
	logic [27:0]   sum_sat;
	logic [12:0]   loaded_sat;

	// sweep limit: lesser of node count and table depth
	assign lim = (17'(node_limit) < 17'(TABLE_ENTRIES)) ?
	             CW'(node_limit) : CW'(TABLE_ENTRIES);

	// entry update arithmetic
	assign add_sum = {1'b0, rd_data_q} + {1'b0, cmd_q.mag};
	assign over    = add_sum > 17'(LOSS_LIMIT);
	assign sub_val = (rd_data_q > cmd_q.mag) ? (rd_data_q - cmd_q.mag) : 16'd0;
	assign new_val = (cmd_q.op == OP_APPLY) ? add_sum[15:0] : sub_val;

	// statistics saturation
	assign sum_sat    = (34'(sum_q) > 34'(SUM_MAX)) ? SUM_MAX : 28'(sum_q);
	assign loaded_sat = (17'(cnt_q) > 17'(LOADED_MAX)) ? LOADED_MAX : 13'(cnt_q);

	assign init_busy = (state_q == ST_INIT);

	// memory port control
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = ptr_q[AW-1:0];
		mem_wd   = 16'd0;
		mem_ra   = AW'(q_head.idx);
		q_pop    = 1'b0;
		sweep_go = 1'b0;
		case (state_q)
			ST_INIT: begin
				sweep_go = ptr_q < CW'(TABLE_ENTRIES);
				mem_we   = sweep_go;
			end
			ST_IDLE: begin
				q_pop = !q_empty;
			end
			ST_EXEC: begin
				mem_wa = AW'(cmd_q.idx);
				mem_wd = new_val;
				mem_we = cmd_q.idx_ok &&
				         ((cmd_q.op == OP_REMOVE) || ((cmd_q.op == OP_APPLY) && !over));
			end
			ST_CLR: begin
				sweep_go = ptr_q < lim;
				mem_we   = sweep_go;
			end
			ST_SCAN: begin
				sweep_go = ptr_q < lim;
				mem_ra   = ptr_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_data_q <= mem[mem_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			ptr_q        <= '0;
			rv_q         <= 1'b0;
			done_q       <= 1'b0;
			apply_cnt_q  <= '0;
			remove_cnt_q <= '0;
			div_start    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			div_start <= 1'b0;
			case (state_q)
				ST_INIT: begin
					if (sweep_go) ptr_q <= ptr_q + CW'(1);
					else          state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					ptr_q <= '0;
					rv_q  <= 1'b0;
					if (!q_empty) begin
						case (q_head.op)
							OP_CLEAR: state_q <= ST_CLR;
							OP_STATS: state_q <= ST_SCAN;
							OP_BAD: begin
								done_q <= 1'b1;
							end
							default:  state_q <= ST_EXEC;
						endcase
					end
				end
				ST_EXEC: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (cmd_q.idx_ok && cmd_q.op == OP_APPLY && !over &&
					    apply_cnt_q != '1)
						apply_cnt_q <= apply_cnt_q + 32'd1;
					if (cmd_q.idx_ok && cmd_q.op == OP_REMOVE && remove_cnt_q != '1)
						remove_cnt_q <= remove_cnt_q + 32'd1;
				end
				ST_CLR: begin
					if (sweep_go) begin
						ptr_q <= ptr_q + CW'(1);
					end else begin
						apply_cnt_q  <= '0;
						remove_cnt_q <= '0;
						done_q       <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					rv_q <= sweep_go;
					if (sweep_go) ptr_q <= ptr_q + CW'(1);
					if (!sweep_go && !rv_q) begin
						if (cnt_q == '0) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							div_start <= 1'b1;
							state_q   <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command capture, accumulators and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q <= q_head;
				sum_q <= '0;
				cnt_q <= '0;
				max_q <= '0;
				if (!q_empty && q_head.op == OP_BAD) begin
					ok_q      <= 1'b0;
					value_q   <= 16'd0;
					sum_out_q <= '0;
					loaded_q  <= '0;
					max_out_q <= '0;
					avg_q     <= '0;
				end
			end
			ST_EXEC: begin
				sum_out_q <= '0;
				loaded_q  <= '0;
				max_out_q <= '0;
				avg_q     <= '0;
				if (cmd_q.op == OP_PEEK) begin
					ok_q    <= 1'b1;
					value_q <= cmd_q.idx_ok ? rd_data_q : 16'd0;
				end else if (!cmd_q.idx_ok) begin
					ok_q    <= 1'b0;
					value_q <= 16'd0;
				end else if (cmd_q.op == OP_READ) begin
					ok_q    <= 1'b1;
					value_q <= rd_data_q;
				end else if (cmd_q.op == OP_APPLY && over) begin
					ok_q    <= 1'b0;
					value_q <= rd_data_q;
				end else begin
					ok_q    <= 1'b1;
					value_q <= new_val;
				end
			end
			ST_CLR: begin
				ok_q      <= 1'b1;
				value_q   <= 16'd0;
				sum_out_q <= '0;
				loaded_q  <= '0;
				max_out_q <= '0;
				avg_q     <= '0;
			end
			ST_SCAN: begin
				if (rv_q && rd_data_q != 16'd0) begin
					sum_q <= sum_q + SW'(rd_data_q);
					cnt_q <= cnt_q + CW'(1);
					if (rd_data_q > max_q) max_q <= rd_data_q;
				end
				ok_q      <= 1'b1;
				value_q   <= 16'd0;
				sum_out_q <= sum_sat;
				loaded_q  <= loaded_sat;
				max_out_q <= max_q;
				avg_q     <= 16'd0;
			end
			ST_DIV: begin
				if (div_done) avg_q <= div_quo;
			end
			default: begin
			end
		endcase
	end

	vlat_divider #(
		.NW(SW),
		.DW(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (sum_q),
		.den     (cnt_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// result record; counters are stable while the strobe is up
	assign res_valid = done_q;
	always_comb begin
		res.ok           = ok_q;
		res.loss_value   = value_q;
		res.applies_done = apply_cnt_q;
		res.removes_done = remove_cnt_q;
		res.active_paths = (apply_cnt_q > remove_cnt_q) ? (apply_cnt_q - remove_cnt_q) : 32'd0;
		res.loss_sum     = sum_out_q;
		res.loaded_nodes = loaded_q;
		res.loss_max     = max_out_q;
		res.loss_avg     = avg_q;
	end

endmodule

`default_nettype wire

// ===== rtl/virtual_loss_accumulator_table_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// virtual_loss_accumulator_table_unit: virtual loss table for tree search
// Per-node virtual loss in units of 1/64 with apply, remove, read, clear
// and statistics requests, plus saturating counters of applies and removes.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with done high, and the receiver
// cannot hold it off. Requests pass through a two-entry queue, so busy rises
// only when that queue is full or while the table is zeroed after reset. In
// the back part apply, remove and read first pop the request and read the
// table, then update and write the entry; an unknown request is answered as
// it is popped. Clear zeroes and statistics scans the first L entries, where
// L is the lesser of the node count register and TABLE_ENTRIES; statistics
// ends with a bit-serial average divide, skipped when no entry is loaded.
// After reset the table is zeroed in a pass over all TABLE_ENTRIES entries
// with busy high; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module virtual_loss_accumulator_table_unit #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int LOSS_LIMIT    = 64000
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	// request
	input  wire  logic        start,
	output logic              busy,
	input  wire  logic [2:0]  req_type,
	input  wire  logic [11:0] entry_index,
	input  wire  logic [15:0] magnitude,
	input  wire  logic        use_default,
	// result
	output logic              done,
	output logic              ok,
	output logic [15:0]       loss_value,
	output logic [31:0]       applies_done,
	output logic [31:0]       removes_done,
	output logic [31:0]       active_paths,
	output logic [27:0]       loss_sum,
	output logic [12:0]       loaded_nodes,
	output logic [15:0]       loss_max,
	output logic [15:0]       loss_avg,
	// configuration
	input  wire  logic        cfg_valid,
	output logic              cfg_ready,
	input  wire  logic [1:0]  cfg_index,
	input  wire  logic [15:0] cfg_data
);
	import vlat_pkg::*;

	logic        enable_q;
	logic [15:0] default_magnitude_q;
	logic [12:0] node_limit_q;

	cmd_t        front_cmd;
	cmd_t        q_head;
	logic        q_empty;
	logic        q_full;
	logic        q_pop;
	logic        init_busy;
	logic        push;
	res_t        res;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q            <= 1'b1;
			default_magnitude_q <= 16'd64;
			node_limit_q        <= 13'd4096;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ENABLE:      enable_q            <= cfg_data[0];
				CFG_DEFAULT_MAG: default_magnitude_q <= cfg_data;
				CFG_NODE_COUNT:  node_limit_q        <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	// request beat handshake
	assign busy = q_full || init_busy;
	assign push = start && !busy;

	vlat_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.req_type         (req_type),
		.entry_index      (entry_index),
		.magnitude        (magnitude),
		.use_default      (use_default),
		.enable           (enable_q),
		.default_magnitude(default_magnitude_q),
		.node_limit       (node_limit_q),
		.cmd              (front_cmd)
	);

	vlat_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(front_cmd),
		.pop     (q_pop),
		.head    (q_head),
		.empty   (q_empty),
		.full    (q_full)
	);

	vlat_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.LOSS_LIMIT   (LOSS_LIMIT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.node_limit(node_limit_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.res_valid (done),
		.res       (res)
	);

	// result ports
	assign ok           = res.ok;
	assign loss_value   = res.loss_value;
	assign applies_done = res.applies_done;
	assign removes_done = res.removes_done;
	assign active_paths = res.active_paths;
	assign loss_sum     = res.loss_sum;
	assign loaded_nodes = res.loaded_nodes;
	assign loss_max     = res.loss_max;
	assign loss_avg     = res.loss_avg;

endmodule

`default_nettype wire
